### hdl/mismatch_tolerant_bitap_matcher_assert.svh
// Assertion macros for the k-mismatch bitap matcher.
`ifndef MISMATCH_TOLERANT_BITAP_MATCHER_ASSERT_SVH
`define MISMATCH_TOLERANT_BITAP_MATCHER_ASSERT_SVH

// Check that the consequent holds in the cycle after the antecedent.
`define MTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define MTB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/mtb_pkg.sv
// Shared constants and types of the k-mismatch bitap matcher.
package mtb_pkg;

  localparam int PATTERN_MAX_DEF   = 31;
  localparam int SUBST_MAX_DEF     = 8;
  localparam int POSITION_BITS_DEF = 24;

  localparam int MODE_BITS     = 2;
  localparam int CHAR_BITS     = 7;
  localparam int INDEX_BITS    = 5;
  localparam int LENGTH_BITS   = 5;
  localparam int SUBST_BITS    = 4;
  localparam int START_BITS    = 24;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 5;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_TEXT  = 2'd1,
    MODE_START = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PATTERN_LENGTH = 1'd0,
    REG_MAX_SUBST      = 1'd1
  } cfg_reg_t;

endpackage

### hdl/mtb_intf.sv
// Request, result and configuration channels of the k-mismatch bitap matcher.
interface mtb_item_if;
  import mtb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [MODE_BITS-1:0]  mode;
  logic [CHAR_BITS-1:0]  char_code;
  logic [INDEX_BITS-1:0] pattern_index;
  modport source (output valid, mode, char_code, pattern_index, input ready);
  modport sink (input valid, mode, char_code, pattern_index, output ready);
endinterface

interface mtb_result_if;
  import mtb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  match_found;
  logic [START_BITS-1:0] match_start;
  modport source (output valid, match_found, match_start, input ready);
  modport sink (input valid, match_found, match_start, output ready);
endinterface

interface mtb_cfg_if;
  import mtb_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/mismatch_tolerant_bitap_matcher.sv
// Shift-or bitap search tolerating a configured number of substitutions.
//
// One request enters per clock cycle while results are taken, and every request gives one
// result: a request register feeds a single level of logic that compares the character
// against all pattern positions at once and updates every error row from its old
// value, and the outcome lands in a result register. While a result waits, one more
// request may enter an empty request register and is held there. Mode load writes a
// pattern character, mode text scans one text character, mode start clears the rows,
// the position counter and the found flag. After the first match, text requests give
// empty results until the next start. Configuration writes are taken in any cycle
// (ready is always high) and act at once; write them only while the block is idle.

`include "mismatch_tolerant_bitap_matcher_assert.svh"

module mismatch_tolerant_bitap_matcher #(
  parameter int PATTERN_MAX   = mtb_pkg::PATTERN_MAX_DEF,
  parameter int SUBST_MAX     = mtb_pkg::SUBST_MAX_DEF,
  parameter int POSITION_BITS = mtb_pkg::POSITION_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  mtb_item_if.sink     item,
  mtb_result_if.source result,
  mtb_cfg_if.sink      cfg
);
  import mtb_pkg::*;

  localparam int ROW_BITS = PATTERN_MAX + 1;
  localparam int ROWS     = SUBST_MAX + 1;
  localparam int PW       = POSITION_BITS + 1;

  function automatic logic [ROW_BITS-1:0] shl(input logic [ROW_BITS-1:0] v);
    return {v[ROW_BITS-2:0], 1'b0};
  endfunction

  logic                     s1_valid;
  logic [MODE_BITS-1:0]     s1_mode;
  logic [CHAR_BITS-1:0]     s1_char;
  logic [INDEX_BITS-1:0]    s1_index;

  logic [LENGTH_BITS-1:0]   pattern_length;
  logic [SUBST_BITS-1:0]    max_subst;

  logic [CHAR_BITS-1:0]     pattern_store [PATTERN_MAX];
  logic [ROW_BITS-1:0]      rows [ROWS];
  logic [POSITION_BITS-1:0] pos;
  logic                     search_done;

  logic                     out_valid;
  logic                     out_found;
  logic [START_BITS-1:0]    out_start;

  logic                     advance;
  logic                     text_step;
  logic [ROW_BITS-1:0]      mask;
  logic [ROW_BITS-1:0]      rows_next [ROWS];
  logic [ROW_BITS-1:0]      sel_row;
  logic                     end_clear;
  logic                     found_next;
  logic [PW-1:0]            pos_inc;
  logic [PW-1:0]            len_ext;
  logic [PW-1:0]            start_full;
  logic [START_BITS-1:0]    start_next;
  logic [POSITION_BITS-1:0] pos_next;

  assign advance    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || advance;
  assign cfg.ready  = 1'b1;

  assign result.valid       = out_valid;
  assign result.match_found = out_found;
  assign result.match_start = out_start;

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_mode  <= item.mode;
      s1_char  <= item.char_code;
      s1_index <= item.pattern_index;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      max_subst      <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PATTERN_LENGTH: pattern_length <= cfg.data[LENGTH_BITS-1:0];
        REG_MAX_SUBST:      max_subst      <= cfg.data[SUBST_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pattern store.
  always_ff @(posedge clk) begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (advance && s1_mode == MODE_LOAD && int'(s1_index) == i) begin
        pattern_store[i] <= s1_char;
      end
    end
  end

  // Mismatch mask and row update.
  always_comb begin
    mask = '1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (i < int'(pattern_length) && pattern_store[i] == s1_char) begin
        mask[i] = 1'b0;
      end
    end
  end

  always_comb begin
    rows_next[0] = shl(rows[0] | mask);
    for (int d = 1; d < ROWS; d++) begin
      rows_next[d] = shl(rows[d-1] & (rows[d] | mask));
    end
  end

  always_comb begin
    sel_row = rows_next[SUBST_MAX];
    for (int d = 0; d < ROWS; d++) begin
      if (int'(max_subst) == d) begin
        sel_row = rows_next[d];
      end
    end
    end_clear = 1'b0;
    for (int j = 1; j <= PATTERN_MAX; j++) begin
      if (int'(pattern_length) == j) begin
        end_clear = !sel_row[j];
      end
    end
  end

  assign text_step  = (s1_mode == MODE_TEXT) && !search_done;
  assign found_next = text_step && end_clear;
  assign pos_next   = (&pos) ? pos : pos + 1'b1;
  assign pos_inc    = {1'b0, pos} + 1'b1;
  assign len_ext    = PW'(pattern_length);
  assign start_full = (pos_inc >= len_ext) ? pos_inc - len_ext : '0;
  assign start_next = found_next ? START_BITS'(start_full) : '0;

  // Search state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < ROWS; d++) begin
        rows[d] <= {{PATTERN_MAX{1'b1}}, 1'b0};
      end
      pos         <= '0;
      search_done <= 1'b0;
    end else if (advance) begin
      case (s1_mode)
        MODE_START: begin
          for (int d = 0; d < ROWS; d++) begin
            rows[d] <= {{PATTERN_MAX{1'b1}}, 1'b0};
          end
          pos         <= '0;
          search_done <= 1'b0;
        end
        MODE_TEXT: begin
          if (!search_done) begin
            for (int d = 0; d < ROWS; d++) begin
              rows[d] <= rows_next[d];
            end
            pos <= pos_next;
            if (found_next) begin
              search_done <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_found <= found_next;
      out_start <= start_next;
    end
  end

  `MTB_ASSERT_NEXT(a_done_sticky, search_done && !(advance && s1_mode == MODE_START), search_done, "found flag dropped without a start")
  `MTB_ASSERT_SAME(a_found_done, out_valid && out_found, search_done, "match reported while search not done")
  `MTB_ASSERT_NEXT(a_hold_request, s1_valid && !advance, s1_valid && $stable(s1_mode) && $stable(s1_char), "stalled request lost")
  `MTB_ASSERT_SAME(a_start_empty, out_valid && !out_found, out_start == '0, "start position set without a match")

endmodule

### dv/mismatch_tolerant_bitap_matcher_tb.sv
// Self-checking testbench for the k-mismatch bitap matcher, with a built-in search predictor.
`timescale 1ns / 1ps

module mismatch_tolerant_bitap_matcher_tb;
  import mtb_pkg::*;

  localparam int ROW_BITS       = PATTERN_MAX_DEF + 1;
  localparam int PHASES         = 13;
  localparam int PHASE_ITEMS    = 30;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_BITS-1:0]  mode;
    logic [CHAR_BITS-1:0]  char_code;
    logic [INDEX_BITS-1:0] pattern_index;
  } char_req_t;

  typedef struct packed {
    logic                  found;
    logic [START_BITS-1:0] start;
  } match_t;

  logic clk;
  logic rst;

  mtb_item_if   item_bus();
  mtb_result_if result_bus();
  mtb_cfg_if    cfg_bus();

  mismatch_tolerant_bitap_matcher i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  char_req_t char_requests[$];
  match_t    expected_matches[$];
  int        error_count;
  int        send_idle_pct;
  int        recv_stall_pct;
  logic      hold_request;
  logic      holding;
  int        hold_count;

  // search predictor state
  logic [CHAR_BITS-1:0]   model_store [PATTERN_MAX_DEF];
  logic [ROW_BITS-1:0]    model_rows [SUBST_MAX_DEF+1];
  logic [START_BITS-1:0]  model_pos;
  logic                   model_done;
  logic [LENGTH_BITS-1:0] model_len;
  logic [SUBST_BITS-1:0]  model_subst;

  // stimulus side view of the pattern store
  logic [CHAR_BITS-1:0]       pattern_copy [PATTERN_MAX_DEF];
  logic [PATTERN_MAX_DEF-1:0] written;
  int                         pushed;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic clear_search();
    for (int d = 0; d <= SUBST_MAX_DEF; d++) model_rows[d] = ~ROW_BITS'(1);
    model_pos  = '0;
    model_done = 1'b0;
  endtask

  task automatic bitap_step(input char_req_t req, output match_t res);
    logic [ROW_BITS-1:0] mask;
    logic [ROW_BITS-1:0] prev;
    logic [ROW_BITS-1:0] cur;
    logic [START_BITS-1:0] pos;
    longint unsigned span;
    int lim;
    res = '0;
    case (req.mode)
      MODE_LOAD: begin
        if (req.pattern_index < PATTERN_MAX_DEF) model_store[req.pattern_index] = req.char_code;
      end
      MODE_START: begin
        clear_search();
      end
      MODE_TEXT: begin
        if (!model_done) begin
          mask = '1;
          for (int i = 0; i < model_len; i++)
            if (model_store[i] == req.char_code) mask[i] = 1'b0;
          prev = model_rows[0];
          model_rows[0] = (model_rows[0] | mask) << 1;
          for (int d = 1; d <= SUBST_MAX_DEF; d++) begin
            cur = model_rows[d];
            model_rows[d] = (prev & (cur | mask)) << 1;
            prev = cur;
          end
          pos = model_pos;
          if (model_pos != '1) model_pos = model_pos + 1'b1;
          lim = (model_subst > SUBST_MAX_DEF) ? SUBST_MAX_DEF : int'(model_subst);
          if (model_len != 0 && !model_rows[lim][model_len]) begin
            model_done = 1'b1;
            res.found = 1'b1;
            span = longint'(pos) + 1;
            if (span >= model_len) res.start = START_BITS'(span - model_len);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [CHAR_BITS-1:0] pick_char();
    if ($urandom_range(9) < 8) return CHAR_BITS'($urandom_range(97, 100));
    return CHAR_BITS'($urandom_range(127));
  endfunction

  task automatic push_request(input logic [MODE_BITS-1:0] mode,
                              input logic [CHAR_BITS-1:0] ch,
                              input logic [INDEX_BITS-1:0] idx);
    char_req_t req;
    req = '{mode: mode, char_code: ch, pattern_index: idx};
    char_requests.push_back(req);
    pushed++;
    if (mode == MODE_LOAD && idx < PATTERN_MAX_DEF) begin
      pattern_copy[idx] = ch;
      written[idx] = 1'b1;
    end
  endtask

  task automatic push_text(input logic [CHAR_BITS-1:0] ch);
    push_request(MODE_TEXT, ch, INDEX_BITS'($urandom_range(31)));
  endtask

  // one search: mostly a planted pattern copy with up to k+1 substitutions
  task automatic gen_search(input int len, input int k);
    int roll;
    int n;
    logic [PATTERN_MAX_DEF-1:0] sub_at;
    logic [CHAR_BITS-1:0] c;
    roll = $urandom_range(99);
    push_request(MODE_START, pick_char(), INDEX_BITS'($urandom_range(31)));
    if (roll < 10) begin
      repeat (len + 3) push_text(pick_char());
    end else begin
      repeat ($urandom_range(4)) push_text(pick_char());
      sub_at = '0;
      if (len > 0) repeat ($urandom_range(k + 1)) sub_at[$urandom_range(len - 1)] = 1'b1;
      n = (roll < 20) ? $urandom_range(len) : len;
      for (int i = 0; i < n; i++) begin
        c = pattern_copy[i];
        if (sub_at[i]) c = c ^ CHAR_BITS'($urandom_range(1, 127));
        push_text(c);
        if (roll >= 20 && roll < 25 && i == n / 2)
          push_request(MODE_LOAD, pick_char(), INDEX_BITS'($urandom_range(31)));
      end
      repeat ($urandom_range(3)) push_text(pick_char());
    end
    if ($urandom_range(9) == 0)
      push_request(MODE_UNUSED, pick_char(), INDEX_BITS'($urandom_range(31)));
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= r;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (char_requests.size() != 0 || item_bus.valid || expected_matches.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : driver
    char_req_t next_req;
    if (rst) begin
      item_bus.valid <= 1'b0;
    end else if (!item_bus.valid || item_bus.ready) begin
      if (char_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = char_requests.pop_front();
        item_bus.valid         <= 1'b1;
        item_bus.mode          <= next_req.mode;
        item_bus.char_code     <= next_req.char_code;
        item_bus.pattern_index <= next_req.pattern_index;
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : hold_off
    if (rst) begin
      holding    <= 1'b0;
      hold_count <= 0;
    end else if (holding) begin
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) holding <= 1'b0;
    end else if (hold_request) begin
      holding    <= 1'b1;
      hold_count <= 0;
    end
  end

  always @(posedge clk) begin : receiver
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    match_t want;
    match_t fresh;
    char_req_t req;
    if (rst) begin
      clear_search();
      model_len   = '0;
      model_subst = '0;
      expected_matches.delete();
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_reg_t'(cfg_bus.index))
          REG_PATTERN_LENGTH: model_len = cfg_bus.data[LENGTH_BITS-1:0];
          REG_MAX_SUBST:      model_subst = cfg_bus.data[SUBST_BITS-1:0];
          default: ;
        endcase
      end
      if (result_bus.valid && result_bus.ready) begin
        if (expected_matches.size() == 0) begin
          report("result with no request waiting");
        end else begin
          want = expected_matches.pop_front();
          if (result_bus.match_found !== want.found)
            report($sformatf("match_found %0b, want %0b", result_bus.match_found, want.found));
          if (result_bus.match_start !== want.start)
            report($sformatf("match_start %0d, want %0d", result_bus.match_start, want.start));
        end
      end
      if (item_bus.valid && item_bus.ready) begin
        req = '{mode: item_bus.mode, char_code: item_bus.char_code,
                pattern_index: item_bus.pattern_index};
        bitap_step(req, fresh);
        expected_matches.push_back(fresh);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
          || (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("mismatch_tolerant_bitap_matcher_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int phase_len [PHASES];
    int phase_sub [PHASES];
    int k;
    int first;
    clk            = 1'b0;
    rst            = 1'b1;
    error_count    = 0;
    pushed         = 0;
    written        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    item_bus.valid         = 1'b0;
    item_bus.mode          = MODE_LOAD;
    item_bus.char_code     = '0;
    item_bus.pattern_index = '0;
    result_bus.ready       = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = REG_PATTERN_LENGTH;
    cfg_bus.data           = '0;
    phase_len = '{1, 31, 31, 5, 8, 0, 3, 12, 2, 20, 31, 6, 4};
    phase_sub = '{0, 8, 15, 2, 1, 3, 19, 0, 9, 4, 0, 1, 8};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // zero length: rows move but nothing matches; unused mode and out-of-range load
    push_request(MODE_UNUSED, 7'd127, 5'd31);
    push_text(7'd127);
    push_text(7'd0);
    push_request(MODE_LOAD, 7'd127, 5'd31);
    push_request(MODE_LOAD, 7'd127, 5'd0);
    push_request(MODE_LOAD, 7'd0, 5'd1);
    push_request(MODE_LOAD, 7'd97, 5'd2);
    push_request(MODE_LOAD, 7'd98, 5'd3);
    wait_idle();

    // exact match, text after a match, one substitution rejected
    write_reg(REG_PATTERN_LENGTH, 5'd4);
    push_request(MODE_START, 7'd0, 5'd0);
    push_text(7'd127);
    push_text(7'd0);
    push_text(7'd97);
    push_text(7'd98);
    push_text(7'd120);
    push_request(MODE_START, 7'd127, 5'd31);
    push_text(7'd122);
    push_text(7'd127);
    push_text(7'd113);
    push_text(7'd97);
    push_text(7'd98);
    wait_idle();

    // one substitution tolerated
    write_reg(REG_MAX_SUBST, 5'd1);
    push_request(MODE_START, 7'd0, 5'd0);
    push_text(7'd122);
    push_text(7'd127);
    push_text(7'd113);
    push_text(7'd97);
    push_text(7'd98);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      if (p == 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      write_reg(REG_PATTERN_LENGTH, CFG_DATA_BITS'(phase_len[p]));
      write_reg(REG_MAX_SUBST, CFG_DATA_BITS'(phase_sub[p]));
      k = phase_sub[p] % 16;
      if (k > SUBST_MAX_DEF) k = SUBST_MAX_DEF;
      for (int i = 0; i < phase_len[p]; i++)
        if (!written[i]) push_request(MODE_LOAD, pick_char(), INDEX_BITS'(i));
      first = pushed;
      while (pushed - first < PHASE_ITEMS) gen_search(phase_len[p], k);
      if (p == 3) begin
        @(negedge clk);
        hold_request = 1'b1;
        do @(negedge clk); while (!holding);
        hold_request = 1'b0;
      end
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (expected_matches.size() != 0)
      report($sformatf("%0d results never arrived", expected_matches.size()));
    if (error_count == 0) begin
      $display("mismatch_tolerant_bitap_matcher_tb: done, clean");
    end else begin
      $display("mismatch_tolerant_bitap_matcher_tb: done, errors");
    end
    $finish;
  end

endmodule
